>>> rtl/core/snc_pkg.sv
`default_nettype none

package snc_pkg;

  // Configuration port geometry
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Fixed field widths
  localparam int WIN_W       = 10;
  localparam int BAND_W      = 16;
  localparam int COUNT_W     = 11;
  localparam int OUT_IDX_W   = 10;
  localparam int OUT_RANGE_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'h7FF;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WINDOW_FIRST = 3'd0,
    CFG_WINDOW_LAST  = 3'd1,
    CFG_RANGE_LOW    = 3'd2,
    CFG_RANGE_HIGH   = 3'd3,
    CFG_CLUSTER_GAP  = 3'd4,
    CFG_MIN_POINTS   = 3'd5,
    CFG_DETECT_LIMIT = 3'd6
  } cfg_reg_t;

  // Reset values of the registers
  localparam logic [WIN_W-1:0]   RST_WINDOW_FIRST = 10'd0;
  localparam logic [WIN_W-1:0]   RST_WINDOW_LAST  = 10'd1023;
  localparam logic [BAND_W-1:0]  RST_RANGE_LOW    = 16'd50;
  localparam logic [BAND_W-1:0]  RST_RANGE_HIGH   = 16'd2000;
  localparam logic [BAND_W-1:0]  RST_CLUSTER_GAP  = 16'd200;
  localparam logic [COUNT_W-1:0] RST_MIN_POINTS   = 11'd5;
  localparam logic [BAND_W-1:0]  RST_DETECT_LIMIT = 16'd6000;

  typedef struct packed {
    logic [WIN_W-1:0]   window_first;
    logic [WIN_W-1:0]   window_last;
    logic [BAND_W-1:0]  range_low_mm;
    logic [BAND_W-1:0]  range_high_mm;
    logic [BAND_W-1:0]  cluster_gap_mm;
    logic [COUNT_W-1:0] min_points;
    logic [BAND_W-1:0]  detect_limit_mm;
  } cfg_t;

  // Classification of one sample, front to back
  typedef struct packed {
    logic valid;
    logic last;
  } item_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/snc_front.sv
`default_nettype none

module snc_front #(
  parameter int MAX_SCAN_POINTS = 1024,
  parameter int RANGE_BITS      = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire snc_pkg::cfg_t                       cfg,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [RANGE_BITS-1:0]               range_mm,
  input  wire logic                                range_finite,
  input  wire logic                                scan_end,
  input  wire logic                                q_full,
  output logic                                     q_push,
  output logic [RANGE_BITS-1:0]                    q_range,
  output logic [$clog2(MAX_SCAN_POINTS)-1:0]       q_idx,
  output snc_pkg::item_flags_t                     q_flags
);

  localparam int IDX_W = $clog2(MAX_SCAN_POINTS);
  localparam int IW    = (IDX_W > snc_pkg::WIN_W) ? IDX_W : snc_pkg::WIN_W;
  localparam int CW    = (RANGE_BITS > snc_pkg::BAND_W) ? RANGE_BITS : snc_pkg::BAND_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SCAN_POINTS - 1);

  logic [IDX_W-1:0] sample_counter;
  logic [IDX_W-1:0] sample_counter_next;
  logic [IW-1:0]    win_lo, win_hi, idx_ext;
  logic [CW-1:0]    r_ext;
  logic             in_window, in_band;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    // Swapped window bounds are taken in either order
    if (cfg.window_first > cfg.window_last) begin
      win_lo = IW'(cfg.window_last);
      win_hi = IW'(cfg.window_first);
    end else begin
      win_lo = IW'(cfg.window_first);
      win_hi = IW'(cfg.window_last);
    end
    idx_ext   = IW'(sample_counter);
    r_ext     = CW'(range_mm);
    in_window = (idx_ext >= win_lo) && (idx_ext <= win_hi);
    in_band   = (r_ext >= CW'(cfg.range_low_mm)) && (r_ext <= CW'(cfg.range_high_mm));
  end

  assign q_range       = range_mm;
  assign q_idx         = sample_counter;
  assign q_flags.valid = range_finite && in_window && in_band;
  assign q_flags.last  = scan_end;

  always_comb begin
    sample_counter_next = sample_counter;
    if (q_push) begin
      if (scan_end || sample_counter == IDX_LAST) begin
        sample_counter_next = '0;
      end else begin
        sample_counter_next = sample_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
    end else begin
      sample_counter <= sample_counter_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/snc_queue.sv
`default_nettype none

module snc_queue #(
  parameter int DATA_W = 28
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   nonempty,
  output logic [DATA_W-1:0]      pop_data
);

  // Two-entry queue
  logic [DATA_W-1:0] entry [2];
  logic              wr_ptr, rd_ptr;
  logic [1:0]        count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/snc_back.sv
`default_nettype none

module snc_back #(
  parameter int MAX_SCAN_POINTS = 1024,
  parameter int RANGE_BITS      = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire snc_pkg::cfg_t                             cfg,
  input  wire logic                                      q_nonempty,
  output logic                                           q_pop,
  input  wire logic [RANGE_BITS-1:0]                     q_range,
  input  wire logic [$clog2(MAX_SCAN_POINTS)-1:0]        q_idx,
  input  wire snc_pkg::item_flags_t                      q_flags,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output logic                                           found,
  output logic                                           exists,
  output logic [snc_pkg::OUT_RANGE_W-1:0]                nearest_mm,
  output logic [snc_pkg::OUT_IDX_W-1:0]                  nearest_index,
  output logic [snc_pkg::OUT_IDX_W-1:0]                  first_index,
  output logic [snc_pkg::OUT_IDX_W-1:0]                  last_index,
  output logic [snc_pkg::COUNT_W-1:0]                    point_count
);

  localparam int IDX_W = $clog2(MAX_SCAN_POINTS);
  localparam int IW    = (IDX_W > snc_pkg::OUT_IDX_W) ? IDX_W : snc_pkg::OUT_IDX_W;
  localparam int CW    = (RANGE_BITS > snc_pkg::BAND_W) ? RANGE_BITS : snc_pkg::BAND_W;
  localparam int NW    = snc_pkg::COUNT_W;

  // Running cluster and best cluster
  logic                  prev_valid;
  logic [RANGE_BITS-1:0] prev_range;
  logic                  open_cluster;
  logic [IDX_W-1:0]      cur_start, cur_end, cur_min_index;
  logic [RANGE_BITS-1:0] cur_min_range;
  logic [NW-1:0]         cur_count;
  logic                  best_found;
  logic [RANGE_BITS-1:0] best_range;
  logic [IDX_W-1:0]      best_min_index, best_start, best_end;
  logic [NW-1:0]         best_count;

  logic                  prev_valid_next;
  logic [RANGE_BITS-1:0] prev_range_next;
  logic                  open_cluster_next;
  logic [IDX_W-1:0]      cur_start_next, cur_end_next, cur_min_index_next;
  logic [RANGE_BITS-1:0] cur_min_range_next;
  logic [NW-1:0]         cur_count_next;
  logic                  best1_found;
  logic [RANGE_BITS-1:0] best1_range;
  logic [IDX_W-1:0]      best1_min_index, best1_start, best1_end;
  logic [NW-1:0]         best1_count;
  logic                  best2_found;
  logic [RANGE_BITS-1:0] best2_range;
  logic [IDX_W-1:0]      best2_min_index, best2_start, best2_end;
  logic [NW-1:0]         best2_count;

  logic [RANGE_BITS-1:0] diff;
  logic                  extend, take_old, take_cur;
  logic [CW-1:0]         nearest_ext;
  logic [IW-1:0]         min_idx_ext, start_ext, end_ext;

  // A scan end waits only while the previous result is still held
  assign q_pop = q_nonempty && (!q_flags.last || !out_valid || out_ready);

  always_comb begin
    diff   = (q_range >= prev_range) ? (q_range - prev_range) : (prev_range - q_range);
    extend = q_flags.valid && open_cluster && prev_valid && (q_idx != '0) &&
             (CW'(diff) <= CW'(cfg.cluster_gap_mm));

    // Close the old cluster unless this sample extends it
    take_old = !extend && open_cluster && (cur_count >= cfg.min_points) &&
               (!best_found || cur_min_range < best_range);
    best1_found     = best_found;
    best1_range     = best_range;
    best1_min_index = best_min_index;
    best1_start     = best_start;
    best1_end       = best_end;
    best1_count     = best_count;
    if (take_old) begin
      best1_found     = 1'b1;
      best1_range     = cur_min_range;
      best1_min_index = cur_min_index;
      best1_start     = cur_start;
      best1_end       = cur_end;
      best1_count     = cur_count;
    end

    cur_start_next     = cur_start;
    cur_end_next       = cur_end;
    cur_min_range_next = cur_min_range;
    cur_min_index_next = cur_min_index;
    cur_count_next     = cur_count;
    prev_range_next    = prev_range;
    open_cluster_next  = q_flags.valid;
    prev_valid_next    = q_flags.valid;
    if (extend) begin
      if (cur_count < snc_pkg::COUNT_MAX) begin
        cur_count_next = cur_count + 1'b1;
      end
      cur_end_next = q_idx;
      if (q_range < cur_min_range) begin
        cur_min_range_next = q_range;
        cur_min_index_next = q_idx;
      end
      prev_range_next = q_range;
    end else if (q_flags.valid) begin
      cur_start_next     = q_idx;
      cur_end_next       = q_idx;
      cur_min_range_next = q_range;
      cur_min_index_next = q_idx;
      cur_count_next     = NW'(1);
      prev_range_next    = q_range;
    end

    // Final close at scan end
    take_cur = open_cluster_next && (cur_count_next >= cfg.min_points) &&
               (!best1_found || cur_min_range_next < best1_range);
    best2_found     = best1_found;
    best2_range     = best1_range;
    best2_min_index = best1_min_index;
    best2_start     = best1_start;
    best2_end       = best1_end;
    best2_count     = best1_count;
    if (take_cur) begin
      best2_found     = 1'b1;
      best2_range     = cur_min_range_next;
      best2_min_index = cur_min_index_next;
      best2_start     = cur_start_next;
      best2_end       = cur_end_next;
      best2_count     = cur_count_next;
    end

    nearest_ext = CW'(best2_range);
    min_idx_ext = IW'(best2_min_index);
    start_ext   = IW'(best2_start);
    end_ext     = IW'(best2_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid     <= 1'b0;
      prev_range     <= '0;
      open_cluster   <= 1'b0;
      cur_start      <= '0;
      cur_end        <= '0;
      cur_min_range  <= '1;
      cur_min_index  <= '0;
      cur_count      <= '0;
      best_found     <= 1'b0;
      best_range     <= '1;
      best_min_index <= '0;
      best_start     <= '0;
      best_end       <= '0;
      best_count     <= '0;
    end else if (q_pop) begin
      if (q_flags.last) begin
        prev_valid     <= 1'b0;
        prev_range     <= '0;
        open_cluster   <= 1'b0;
        cur_start      <= '0;
        cur_end        <= '0;
        cur_min_range  <= '1;
        cur_min_index  <= '0;
        cur_count      <= '0;
        best_found     <= 1'b0;
        best_range     <= '1;
        best_min_index <= '0;
        best_start     <= '0;
        best_end       <= '0;
        best_count     <= '0;
      end else begin
        prev_valid     <= prev_valid_next;
        prev_range     <= prev_range_next;
        open_cluster   <= open_cluster_next;
        cur_start      <= cur_start_next;
        cur_end        <= cur_end_next;
        cur_min_range  <= cur_min_range_next;
        cur_min_index  <= cur_min_index_next;
        cur_count      <= cur_count_next;
        best_found     <= best1_found;
        best_range     <= best1_range;
        best_min_index <= best1_min_index;
        best_start     <= best1_start;
        best_end       <= best1_end;
        best_count     <= best1_count;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && q_flags.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_flags.last) begin
      found  <= best2_found;
      exists <= best2_found && (nearest_ext <= CW'(cfg.detect_limit_mm));
      if (best2_found) begin
        nearest_mm    <= nearest_ext[snc_pkg::OUT_RANGE_W-1:0];
        nearest_index <= min_idx_ext[snc_pkg::OUT_IDX_W-1:0];
        first_index   <= start_ext[snc_pkg::OUT_IDX_W-1:0];
        last_index    <= end_ext[snc_pkg::OUT_IDX_W-1:0];
        point_count   <= best2_count;
      end else begin
        nearest_mm    <= '1;
        nearest_index <= '0;
        first_index   <= '0;
        last_index    <= '0;
        point_count   <= '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/scan_nearest_cluster_finder_core.sv
// Nearest-cluster finder for one range scan.
// Input channel (in_valid/in_ready): one range sample per item with its finite
// flag and an end-of-scan mark; the sample index is counted internally from 0
// and wraps at MAX_SCAN_POINTS.
// Output channel (out_valid/out_ready): one result item per scan, issued for
// the sample marked scan_end, giving the nearest qualifying cluster.
// Config port (cfg_we/cfg_index/cfg_data): single-cycle register writes; the user
// must write only while the block is idle (unenforced); unknown indexes are ignored.
// Throughput: one sample per cycle while in_ready is high. The front stage
// classifies each sample (window and range band) and pushes it into a two-entry
// queue; the back stage runs the cluster tracker, one sample per cycle unless stalled.
// Path: a scan_end item is registered in the queue, then in the result register.
// Stall: a held result blocks only the next scan_end item in the back stage;
// ordinary samples keep flowing until the queue fills, then in_ready drops.
// Reset: registers go to their defaults and all per-scan state is cleared.
`default_nettype none

module scan_nearest_cluster_finder_core #(
  parameter int MAX_SCAN_POINTS = 1024,
  parameter int RANGE_BITS      = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // config
  input  wire logic                             cfg_we,
  input  wire logic [snc_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  wire logic [snc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // samples
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [RANGE_BITS-1:0]            range_mm,
  input  wire logic                             range_finite,
  input  wire logic                             scan_end,
  // results
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  found,
  output logic                                  exists,
  output logic [snc_pkg::OUT_RANGE_W-1:0]       nearest_mm,
  output logic [snc_pkg::OUT_IDX_W-1:0]         nearest_index,
  output logic [snc_pkg::OUT_IDX_W-1:0]         first_index,
  output logic [snc_pkg::OUT_IDX_W-1:0]         last_index,
  output logic [snc_pkg::COUNT_W-1:0]           point_count
);

  localparam int IDX_W = $clog2(MAX_SCAN_POINTS);
  localparam int Q_W   = RANGE_BITS + IDX_W + $bits(snc_pkg::item_flags_t);

  snc_pkg::cfg_t cfg;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_first    <= snc_pkg::RST_WINDOW_FIRST;
      cfg.window_last     <= snc_pkg::RST_WINDOW_LAST;
      cfg.range_low_mm    <= snc_pkg::RST_RANGE_LOW;
      cfg.range_high_mm   <= snc_pkg::RST_RANGE_HIGH;
      cfg.cluster_gap_mm  <= snc_pkg::RST_CLUSTER_GAP;
      cfg.min_points      <= snc_pkg::RST_MIN_POINTS;
      cfg.detect_limit_mm <= snc_pkg::RST_DETECT_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        snc_pkg::CFG_WINDOW_FIRST: cfg.window_first   <= cfg_data[snc_pkg::WIN_W-1:0];
        snc_pkg::CFG_WINDOW_LAST:  cfg.window_last    <= cfg_data[snc_pkg::WIN_W-1:0];
        snc_pkg::CFG_RANGE_LOW:    cfg.range_low_mm   <= cfg_data[snc_pkg::BAND_W-1:0];
        snc_pkg::CFG_RANGE_HIGH:   cfg.range_high_mm  <= cfg_data[snc_pkg::BAND_W-1:0];
        snc_pkg::CFG_CLUSTER_GAP:  cfg.cluster_gap_mm <= cfg_data[snc_pkg::BAND_W-1:0];
        snc_pkg::CFG_MIN_POINTS:   cfg.min_points     <= cfg_data[snc_pkg::COUNT_W-1:0];
        snc_pkg::CFG_DETECT_LIMIT: cfg.detect_limit_mm <= cfg_data[snc_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Front -> queue
  logic                  q_full, q_push, q_nonempty, q_pop;
  logic [RANGE_BITS-1:0] f_range, b_range;
  logic [IDX_W-1:0]      f_idx, b_idx;
  snc_pkg::item_flags_t  f_flags, b_flags;
  logic [Q_W-1:0]        q_wdata, q_rdata;

  snc_front #(
    .MAX_SCAN_POINTS (MAX_SCAN_POINTS),
    .RANGE_BITS      (RANGE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .range_mm     (range_mm),
    .range_finite (range_finite),
    .scan_end     (scan_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_range      (f_range),
    .q_idx        (f_idx),
    .q_flags      (f_flags)
  );

  assign q_wdata = {f_range, f_idx, f_flags};

  snc_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_data  (q_rdata)
  );

  assign {b_range, b_idx, b_flags} = q_rdata;

  snc_back #(
    .MAX_SCAN_POINTS (MAX_SCAN_POINTS),
    .RANGE_BITS      (RANGE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_nonempty    (q_nonempty),
    .q_pop         (q_pop),
    .q_range       (b_range),
    .q_idx         (b_idx),
    .q_flags       (b_flags),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .exists        (exists),
    .nearest_mm    (nearest_mm),
    .nearest_index (nearest_index),
    .first_index   (first_index),
    .last_index    (last_index),
    .point_count   (point_count)
  );

endmodule

`default_nettype wire

>>> test/scan_nearest_cluster_finder_core_test.sv
`default_nettype none

module scan_nearest_cluster_finder_core_test;

  localparam int SCAN_POINTS = 1024;
  localparam int IDX_W  = snc_pkg::WIN_W;
  localparam int RNG_W  = snc_pkg::BAND_W;
  localparam int CFG_DW = snc_pkg::CFG_DATA_W;
  // Leave a margin after the reports so the sample queue is empty too.
  localparam int SETTLE_CYCLES = 8;
  // Index with no register behind it; writes there must be dropped.
  localparam logic [snc_pkg::CFG_ADDR_W-1:0] CFG_NO_REG = 3'd7;
  localparam int MAX_SHOWN = 10;

  // One result item as seen on the output channel.
  typedef struct packed {
    logic                            found;
    logic                            exists;
    logic [snc_pkg::OUT_RANGE_W-1:0] nearest_mm;
    logic [snc_pkg::OUT_IDX_W-1:0]   nearest_index;
    logic [snc_pkg::OUT_IDX_W-1:0]   first_index;
    logic [snc_pkg::OUT_IDX_W-1:0]   last_index;
    logic [snc_pkg::COUNT_W-1:0]     point_count;
  } report_t;

  // Tracks clusters over the accepted samples and keeps the reports still due.
  class cluster_tracker;
    snc_pkg::cfg_t                setup;
    logic [IDX_W-1:0]             next_index;
    bit                           last_valid;
    logic [RNG_W-1:0]             last_range;
    bit                           run_open;
    logic [IDX_W-1:0]             run_first, run_last, run_min_index;
    logic [RNG_W-1:0]             run_min;
    logic [snc_pkg::COUNT_W-1:0]  run_count;
    bit                           have_best;
    logic [RNG_W-1:0]             best_min;
    logic [IDX_W-1:0]             best_min_index, best_first, best_last;
    logic [snc_pkg::COUNT_W-1:0]  best_count;
    report_t                      due_reports[$];
    int                           errors;
    int                           checked;

    function new();
      setup.window_first    = snc_pkg::RST_WINDOW_FIRST;
      setup.window_last     = snc_pkg::RST_WINDOW_LAST;
      setup.range_low_mm    = snc_pkg::RST_RANGE_LOW;
      setup.range_high_mm   = snc_pkg::RST_RANGE_HIGH;
      setup.cluster_gap_mm  = snc_pkg::RST_CLUSTER_GAP;
      setup.min_points      = snc_pkg::RST_MIN_POINTS;
      setup.detect_limit_mm = snc_pkg::RST_DETECT_LIMIT;
      errors  = 0;
      checked = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      next_index     = '0;
      last_valid     = 1'b0;
      last_range     = '0;
      run_open       = 1'b0;
      run_first      = '0;
      run_last       = '0;
      run_min        = '1;
      run_min_index  = '0;
      run_count      = '0;
      have_best      = 1'b0;
      best_min       = '1;
      best_min_index = '0;
      best_first     = '0;
      best_last      = '0;
      best_count     = '0;
    endfunction

    function void set_reg(logic [snc_pkg::CFG_ADDR_W-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        snc_pkg::CFG_WINDOW_FIRST: setup.window_first    = data[snc_pkg::WIN_W-1:0];
        snc_pkg::CFG_WINDOW_LAST:  setup.window_last     = data[snc_pkg::WIN_W-1:0];
        snc_pkg::CFG_RANGE_LOW:    setup.range_low_mm    = data[snc_pkg::BAND_W-1:0];
        snc_pkg::CFG_RANGE_HIGH:   setup.range_high_mm   = data[snc_pkg::BAND_W-1:0];
        snc_pkg::CFG_CLUSTER_GAP:  setup.cluster_gap_mm  = data[snc_pkg::BAND_W-1:0];
        snc_pkg::CFG_MIN_POINTS:   setup.min_points      = data[snc_pkg::COUNT_W-1:0];
        snc_pkg::CFG_DETECT_LIMIT: setup.detect_limit_mm = data[snc_pkg::BAND_W-1:0];
        default: ;
      endcase
    endfunction

    // Strictly smaller minimum replaces the best, so earlier clusters win ties.
    function void close_run();
      if (run_open && run_count >= setup.min_points && (!have_best || run_min < best_min)) begin
        have_best      = 1'b1;
        best_min       = run_min;
        best_min_index = run_min_index;
        best_first     = run_first;
        best_last      = run_last;
        best_count     = run_count;
      end
      run_open = 1'b0;
    endfunction

    function void note_sample(logic [RNG_W-1:0] r, logic fin, logic last);
      logic [IDX_W-1:0] idx, lo, hi;
      logic [RNG_W-1:0] step;
      bit               ok;
      report_t          rep;
      idx = next_index;
      lo  = (setup.window_first > setup.window_last) ? setup.window_last : setup.window_first;
      hi  = (setup.window_first > setup.window_last) ? setup.window_first : setup.window_last;
      ok  = fin && idx >= lo && idx <= hi &&
            r >= setup.range_low_mm && r <= setup.range_high_mm;
      if (ok) begin
        step = (r >= last_range) ? r - last_range : last_range - r;
        // no cluster continues across the index wrap
        if (run_open && last_valid && idx != 0 && step <= setup.cluster_gap_mm) begin
          if (run_count != snc_pkg::COUNT_MAX) run_count++;
          run_last = idx;
          if (r < run_min) begin
            run_min       = r;
            run_min_index = idx;
          end
        end else begin
          close_run();
          run_open      = 1'b1;
          run_first     = idx;
          run_last      = idx;
          run_min       = r;
          run_min_index = idx;
          run_count     = 1;
        end
        last_range = r;
      end else begin
        close_run();
      end
      last_valid = ok;
      next_index = (idx == IDX_W'(SCAN_POINTS - 1)) ? '0 : idx + 1'b1;
      if (last) begin
        close_run();
        if (have_best) begin
          rep.found         = 1'b1;
          rep.exists        = best_min <= setup.detect_limit_mm;
          rep.nearest_mm    = best_min;
          rep.nearest_index = best_min_index;
          rep.first_index   = best_first;
          rep.last_index    = best_last;
          rep.point_count   = best_count;
        end else begin
          rep = '0;
          rep.nearest_mm = '1;
        end
        due_reports = {due_reports, rep};
        clear_scan();
      end
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= MAX_SHOWN) $display("mismatch: %s", what);
    endfunction

    function void cmp(string name, logic [RNG_W-1:0] want_v, logic [RNG_W-1:0] got_v);
      if (want_v !== got_v)
        flag($sformatf("%s expected %0d got %0d", name, want_v, got_v));
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (due_reports.size() == 0) begin
        flag($sformatf("result with none due: found %0d nearest_mm %0d count %0d",
                       got.found, got.nearest_mm, got.point_count));
        return;
      end
      want = due_reports.pop_front();
      checked++;
      cmp("found", RNG_W'(want.found), RNG_W'(got.found));
      cmp("exists", RNG_W'(want.exists), RNG_W'(got.exists));
      cmp("nearest_mm", want.nearest_mm, got.nearest_mm);
      cmp("nearest_index", RNG_W'(want.nearest_index), RNG_W'(got.nearest_index));
      cmp("first_index", RNG_W'(want.first_index), RNG_W'(got.first_index));
      cmp("last_index", RNG_W'(want.last_index), RNG_W'(got.last_index));
      cmp("point_count", RNG_W'(want.point_count), RNG_W'(got.point_count));
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [snc_pkg::CFG_ADDR_W-1:0]  cfg_index = '0;
  logic [CFG_DW-1:0]               cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [RNG_W-1:0]                range_mm = '0;
  logic                            range_finite = 1'b0;
  logic                            scan_end = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            found;
  logic                            exists;
  logic [snc_pkg::OUT_RANGE_W-1:0] nearest_mm;
  logic [snc_pkg::OUT_IDX_W-1:0]   nearest_index;
  logic [snc_pkg::OUT_IDX_W-1:0]   first_index;
  logic [snc_pkg::OUT_IDX_W-1:0]   last_index;
  logic [snc_pkg::COUNT_W-1:0]     point_count;

  cluster_tracker board = new();
  int send_idle_pct  = 0;   // chance per item slot that the sender holds off
  int recv_stall_pct = 0;   // chance per cycle that the receiver drops ready
  int samples_taken  = 0;
  int scans_taken    = 0;
  int setups_loaded  = 0;

  scan_nearest_cluster_finder_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .range_mm      (range_mm),
    .range_finite  (range_finite),
    .scan_end      (scan_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .exists        (exists),
    .nearest_mm    (nearest_mm),
    .nearest_index (nearest_index),
    .first_index   (first_index),
    .last_index    (last_index),
    .point_count   (point_count)
  );

  always #4 clk = ~clk;

  // Receiver: ready changes only on the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Both channels are sampled on the rising edge, before any register update.
  // Inputs are noted first so a result can only match an item already taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        board.note_sample(range_mm, range_finite, scan_end);
        samples_taken++;
        if (scan_end) scans_taken++;
      end
      if (out_valid && out_ready)
        board.check_report('{found, exists, nearest_mm, nearest_index,
                             first_index, last_index, point_count});
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_sample(input logic [RNG_W-1:0] r, input logic fin, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    range_mm     <= r;
    range_finite <= fin;
    scan_end     <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender goes quiet until every due report is back, then waits a further settling margin.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.due_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [snc_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    board.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic load_setup(input logic [CFG_DW-1:0] wf, input logic [CFG_DW-1:0] wl,
                            input logic [CFG_DW-1:0] lo, input logic [CFG_DW-1:0] hi,
                            input logic [CFG_DW-1:0] gap, input logic [CFG_DW-1:0] minp,
                            input logic [CFG_DW-1:0] limit);
    write_reg(snc_pkg::CFG_WINDOW_FIRST, wf);
    write_reg(snc_pkg::CFG_WINDOW_LAST, wl);
    write_reg(snc_pkg::CFG_RANGE_LOW, lo);
    write_reg(snc_pkg::CFG_RANGE_HIGH, hi);
    write_reg(snc_pkg::CFG_CLUSTER_GAP, gap);
    write_reg(snc_pkg::CFG_MIN_POINTS, minp);
    write_reg(snc_pkg::CFG_DETECT_LIMIT, limit);
    cfg_we <= 1'b0;
    setups_loaded++;
  endtask

  // A few fixed corner setups among random ones. Random window and count
  // values carry junk in the unused upper bits of the data word.
  task automatic apply_setup(input int kind);
    int lo_v;
    lo_v = $urandom_range(800);
    case (kind)
      1: load_setup(0, 1023, 0, 65535, 0, 1, 0);             // widest band, no gap
      3: load_setup(1023, 0, 0, 65535, 65535, 0, 65535);     // swapped full window
      5: load_setup(0, 40, 2000, 100, 200, 1, 6000);         // empty band
      7: load_setup(3, 30, 50, 2000, 200, 2047, 6000);       // count never reached
      9: load_setup(0, 1023, 50, 2000, 150, 1024, 6000);     // largest sane count
      default: load_setup(CFG_DW'($urandom_range(12) | ($urandom_range(63) << snc_pkg::WIN_W)),
                          CFG_DW'($urandom_range(50) | ($urandom_range(63) << snc_pkg::WIN_W)),
                          CFG_DW'(lo_v), CFG_DW'(lo_v + $urandom_range(3000)),
                          CFG_DW'($urandom_range(400)),
                          CFG_DW'($urandom_range(6, 1) |
                                  ($urandom_range(31) << snc_pkg::COUNT_W)),
                          CFG_DW'($urandom_range(3000)));
    endcase
  endtask

  function automatic int clamp16(input int v);
    return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
  endfunction

  // Range in or near the current band, often right on or just past an edge.
  function automatic int band_value();
    int lo_v, hi_v, pick;
    lo_v = int'(board.setup.range_low_mm);
    hi_v = int'(board.setup.range_high_mm);
    pick = $urandom_range(9);
    if (lo_v > hi_v) return $urandom_range(65535);
    case (pick)
      0: return lo_v;
      1: return hi_v;
      2: return clamp16(lo_v - 1);
      3: return clamp16(hi_v + 1);
      default: return $urandom_range(hi_v, lo_v);
    endcase
  endfunction

  // Mostly a walk through the band with steps near the gap threshold, so
  // clusters form and break; some non-finite samples and raw noise mixed in.
  task automatic run_scan(input int len);
    int lvl, step, gap_v, pick;
    logic [RNG_W-1:0] r;
    logic fin;
    lvl = band_value();
    for (int i = 0; i < len; i++) begin
      gap_v = int'(board.setup.cluster_gap_mm);
      pick  = $urandom_range(99);
      fin   = 1'b1;
      if (pick < 6) begin
        fin = 1'b0;
        r   = RNG_W'($urandom_range(65535));
      end else if (pick < 12) begin
        r = RNG_W'($urandom_range(65535));
      end else if (pick < 22) begin
        lvl = band_value();
        r   = RNG_W'(lvl);
      end else begin
        pick = $urandom_range(9);
        step = (pick < 3) ? gap_v : (pick == 3) ? gap_v + 1 : $urandom_range(gap_v);
        lvl  = clamp16($urandom_range(1) ? lvl + step : lvl - step);
        r    = RNG_W'(lvl);
      end
      send_sample(r, fin, i == len - 1);
    end
  endtask

  initial begin
    int budget;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // --- directed part, reset setup, no idling ---
    // lone sample above the band: no cluster at all
    send_sample(16'hFFFF, 1'b1, 1'b1);
    // two five-point clusters with the same minimum; the first one must win,
    // a non-finite sample splits them and an under-range sample ends the second
    send_sample(300, 1'b1, 1'b0);
    send_sample(120, 1'b1, 1'b0);
    send_sample(250, 1'b1, 1'b0);
    send_sample(120, 1'b1, 1'b0);
    send_sample(310, 1'b1, 1'b0);
    send_sample(120, 1'b0, 1'b0);
    send_sample(130, 1'b1, 1'b0);
    send_sample(120, 1'b1, 1'b0);
    send_sample(200, 1'b1, 1'b0);
    send_sample(310, 1'b1, 1'b0);
    send_sample(500, 1'b1, 1'b0);
    send_sample(0, 1'b1, 1'b0);
    send_sample(2000, 1'b1, 1'b1);
    // sender holds off here until the reports above are all back
    settle();

    // dropped write, then zero gap, zero count, full band
    write_reg(CFG_NO_REG, 16'h0123);
    load_setup(0, 1023, 0, 65535, 0, 0, 65535);
    send_sample(16'hFFFF, 1'b1, 1'b0);
    send_sample(16'hFFFF, 1'b1, 1'b0);
    send_sample(0, 1'b1, 1'b1);
    settle();

    // window given back to front, nearest just past the detect limit
    load_setup(5, 2, 0, 65535, 0, 1, 999);
    repeat (6) send_sample(1000, 1'b1, 1'b0);
    send_sample(16'hFFFF, 1'b0, 1'b1);
    settle();

    // --- random part: four idling modes, three setups each ---
    for (int phase = 0; phase < 4; phase++) begin
      for (int seg = 0; seg < 3; seg++) begin
        settle();
        case (phase)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
          default: begin send_idle_pct = 34; recv_stall_pct = 34; end
        endcase
        apply_setup(phase * 3 + seg);
        budget = 60;
        while (budget > 0) begin
          int len;
          len = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(40, 4);
          run_scan(len);
          budget -= len;
        end
      end
    end
    settle();

    $display("covered %0d samples in %0d scans over %0d register setups, %0d reports compared",
             samples_taken, scans_taken, setups_loaded, board.checked);
    $display("all four idling modes, empty band and swapped window included");
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("timeout with %0d reports still due", board.due_reports.size());
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/snc_pkg.sv
rtl/core/snc_front.sv
rtl/core/snc_queue.sv
rtl/core/snc_back.sv
rtl/core/scan_nearest_cluster_finder_core.sv
test/scan_nearest_cluster_finder_core_test.sv
